// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers shared by the rtl files
// all checks are sampled on clk and are off while arst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every sampled edge
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// whenever ante holds, cons must hold in the same cycle
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/usutc_pkg.sv =====
// ----------------------------------------------------------------------------
// usutc_pkg
// constants and types for the unix seconds to utc civil converter
// ----------------------------------------------------------------------------
`default_nettype none

package usutc_pkg;

	// total pipeline depth from start to done
	localparam int unsigned LATENCY = 9;

	// day shift so that day zero is 0000-03-01
	localparam logic [19:0] SHIFT_DAYS = 20'd719468;
	localparam logic [19:0] ERA_DAYS   = 20'd146097;
	localparam logic [17:0] CENT_DAYS  = 18'd36524;
	localparam logic [17:0] ERA_LAST   = 18'd146096;

	// reciprocals for exact division by constants: q = (x * RECIP) >> SHIFT
	localparam logic [30:0] RECIP_15  = 31'd1145324613;  // x < 2^30
	localparam int unsigned SHIFT_15  = 34;
	localparam logic [18:0] RECIP_3   = 19'd349526;      // x < 2^19
	localparam int unsigned SHIFT_3   = 20;
	localparam logic [15:0] RECIP_365 = 16'd45965;       // x < 1864135
	localparam int unsigned SHIFT_365 = 24;
	localparam logic [12:0] RECIP_153 = 13'd6854;        // x < 12192
	localparam int unsigned SHIFT_153 = 20;
	localparam logic [13:0] RECIP_5   = 14'd13108;       // x < 16384
	localparam int unsigned SHIFT_5   = 16;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
	} civil_date_t;

endpackage

`default_nettype wire

// ===== rtl/usutc_civil_date.sv =====
// ----------------------------------------------------------------------------
// usutc_civil_date
// six stage days-to-civil pipeline: day count since 1970 to year, month, day
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module usutc_civil_date (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic [15:0]            day_count,
	output logic                        out_valid,
	output usutc_pkg::civil_date_t      date
);

	logic v_s4, v_s5, v_s6, v_s7, v_s8, v_s9;

	// stage 4 signals
	logic [19:0] shifted;
	logic        era_hi;
	logic [2:0]  era_s4;
	logic [17:0] doe_s4;
	// stage 5 signals
	logic [31:0] prod_a;
	logic [6:0]  a_s5;
	logic [2:0]  b_s5;
	logic        c_s5;
	logic [17:0] doe_s5;
	logic [2:0]  era_s5;
	// stage 6 signals
	logic [17:0] t_yoe;
	logic [33:0] prod_y;
	logic [8:0]  yoe_s6;
	logic [17:0] doe_s6;
	logic [2:0]  era_s6;
	// stage 7 signals
	logic [1:0]  cent;
	logic [17:0] yr_start;
	logic [8:0]  doy_s7;
	logic [8:0]  yoe_s7;
	logic [2:0]  era_s7;
	// stage 8 signals
	logic [10:0] y_mp;
	logic [23:0] prod_mp;
	logic [3:0]  mp_s8;
	logic [8:0]  doy_s8;
	logic [8:0]  yoe_s8;
	logic [2:0]  era_s8;
	// stage 9 signals
	logic [10:0] z_md;
	logic [24:0] prod_md;
	logic [8:0]  q_md;
	logic        jan_feb;
	usutc_pkg::civil_date_t date_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else begin
			v_s4 <= in_valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// era split: a 32-bit unsigned time always lands in era 4 or 5
	assign shifted = 20'(day_count) + usutc_pkg::SHIFT_DAYS;
	assign era_hi  = (shifted >= 20'(5 * usutc_pkg::ERA_DAYS));

	// day of era / 1460 via reciprocal of 365 on doe / 4
	assign prod_a = 32'(doe_s4[17:2]) * 32'(usutc_pkg::RECIP_365);

	// year of era
	assign t_yoe  = 18'(doe_s5 + 18'(b_s5) - 18'(a_s5) - 18'(c_s5));
	assign prod_y = 34'(t_yoe) * 34'(usutc_pkg::RECIP_365);

	// day of year, march based
	assign cent     = 2'(yoe_s6 >= 9'd100) + 2'(yoe_s6 >= 9'd200) + 2'(yoe_s6 >= 9'd300);
	assign yr_start = 18'(18'(yoe_s6) * 18'd365) + 18'(yoe_s6[8:2]) - 18'(cent);

	// march based month index
	assign y_mp    = 11'(11'(doy_s7) * 11'd5) + 11'd2;
	assign prod_mp = 24'(y_mp) * 24'(usutc_pkg::RECIP_153);

	// day of month and january based month
	assign z_md    = 11'(11'(mp_s8) * 11'd153) + 11'd2;
	assign prod_md = 25'(z_md) * 25'(usutc_pkg::RECIP_5);
	assign q_md    = prod_md[usutc_pkg::SHIFT_5 +: 9];
	assign jan_feb = (mp_s8 >= 4'd10);

	always_comb begin
		date_s9.day   = 5'(doy_s8 - q_md + 9'd1);
		date_s9.month = jan_feb ? 4'(mp_s8 - 4'd9) : 4'(mp_s8 + 4'd3);
		date_s9.year  = 12'(yoe_s8) + 12'(12'(era_s8) * 12'd400) + 12'(jan_feb);
	end

	always_ff @(posedge clk) begin
		era_s4 <= era_hi ? 3'd5 : 3'd4;
		doe_s4 <= era_hi ? 18'(shifted - 20'(5 * usutc_pkg::ERA_DAYS))
		                 : 18'(shifted - 20'(4 * usutc_pkg::ERA_DAYS));

		a_s5   <= prod_a[usutc_pkg::SHIFT_365 +: 7];
		b_s5   <= 3'(doe_s4 >= usutc_pkg::CENT_DAYS) + 3'(doe_s4 >= 18'(2 * usutc_pkg::CENT_DAYS))
		        + 3'(doe_s4 >= 18'(3 * usutc_pkg::CENT_DAYS))
		        + 3'(doe_s4 >= 18'(4 * usutc_pkg::CENT_DAYS));
		c_s5   <= (doe_s4 == usutc_pkg::ERA_LAST);
		doe_s5 <= doe_s4;
		era_s5 <= era_s4;

		yoe_s6 <= prod_y[usutc_pkg::SHIFT_365 +: 9];
		doe_s6 <= doe_s5;
		era_s6 <= era_s5;

		doy_s7 <= 9'(doe_s6 - yr_start);
		yoe_s7 <= yoe_s6;
		era_s7 <= era_s6;

		mp_s8  <= prod_mp[usutc_pkg::SHIFT_153 +: 4];
		doy_s8 <= doy_s7;
		yoe_s8 <= yoe_s7;
		era_s8 <= era_s7;

		date   <= date_s9;
	end

	assign out_valid = v_s9;

	`ASSERT_IMPLY(a_date_latency, out_valid, $past(in_valid, 6), "date without a request")
	`ASSERT_IMPLY(a_date_range, out_valid,
		date.month >= 4'd1 && date.month <= 4'd12 && date.day >= 5'd1,
		"month or day out of range")
	`ASSERT_IMPLY(a_year_range, out_valid,
		date.year >= 12'd1970 && date.year <= 12'd2106, "year out of range")

endmodule

`default_nettype wire

// ===== rtl/unix_seconds_to_utc_civil_unit.sv =====
// ----------------------------------------------------------------------------
// unix_seconds_to_utc_civil_unit
// unix seconds to utc calendar date and time of day, fully pipelined
// ----------------------------------------------------------------------------
// usage
//   request channel: drive epoch_seconds and pulse start; a request is taken
//   at every rising edge with start high and busy low. busy is held low, so
//   one request can be issued every cycle.
//   result channel: done is high for exactly one cycle with year, month,
//   day_of_month, hour, minute and second valid in that same cycle. the
//   receiver cannot stall; results leave in request order.
//   throughput one request per cycle. depth is set by the chain of constant
//   divisions (60, 60, 24, era, 1460/36524, 365, 153, 5), at most one
//   reciprocal multiplier per stage.
//   reset: arst_n clears all valid bits, so no stale result is shown; the
//   data path registers are not reset.
// stages
//   s1  seconds / 60
//   s2  second, minutes / 60
//   s3  minute, hours / 24 -> day count
//   s4..s9  days-to-civil in usutc_civil_date, hour delayed alongside
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module unix_seconds_to_utc_civil_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [31:0] epoch_seconds,
	output logic             done,
	output logic [11:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [4:0]       hour,
	output logic [5:0]       minute,
	output logic [5:0]       second
);

	logic accept;
	logic v_s1, v_s2, v_s3;

	// stage 1: total minutes
	logic [60:0] prod1;
	logic [26:0] q1_s1;
	logic [5:0]  secs_lo_s1;
	// stage 2: second, total hours
	logic [55:0] prod2;
	logic [20:0] q2_s2;
	logic [5:0]  q1_lo_s2;
	logic [5:0]  sec_s2;
	// stage 3: minute, day count
	logic [36:0] prod3;
	logic [15:0] day_s3;
	logic [4:0]  q2_lo_s3;
	logic [5:0]  min_s3;
	logic [5:0]  sec_s3;
	// time of day delayed to line up with the date pipeline
	logic [4:0]  hour_s4, hour_s5, hour_s6, hour_s7, hour_s8, hour_s9;
	logic [5:0]  min_s4, min_s5, min_s6, min_s7, min_s8, min_s9;
	logic [5:0]  sec_s4, sec_s5, sec_s6, sec_s7, sec_s8, sec_s9;

	logic                   date_valid;
	usutc_pkg::civil_date_t date;

	// never blocks: every stage advances each cycle
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// seconds / 60 = (seconds / 4) / 15
	assign prod1 = 61'(epoch_seconds[31:2]) * 61'(usutc_pkg::RECIP_15);
	// minutes / 60, same reciprocal
	assign prod2 = 56'(q1_s1[26:2]) * 56'(usutc_pkg::RECIP_15);
	// hours / 24 = (hours / 8) / 3
	assign prod3 = 37'(q2_s2[20:3]) * 37'(usutc_pkg::RECIP_3);

	always_ff @(posedge clk) begin
		q1_s1      <= prod1[usutc_pkg::SHIFT_15 +: 27];
		secs_lo_s1 <= epoch_seconds[5:0];

		// remainders only need the low bits, the result is below 64
		sec_s2     <= 6'(secs_lo_s1 - 6'(q1_s1 * 7'd60));
		q1_lo_s2   <= q1_s1[5:0];
		q2_s2      <= prod2[usutc_pkg::SHIFT_15 +: 21];

		min_s3     <= 6'(q1_lo_s2 - 6'(q2_s2 * 7'd60));
		sec_s3     <= sec_s2;
		q2_lo_s3   <= q2_s2[4:0];
		day_s3     <= prod3[usutc_pkg::SHIFT_3 +: 16];

		hour_s4 <= 5'(q2_lo_s3 - 5'(day_s3 * 5'd24));
		min_s4  <= min_s3;
		sec_s4  <= sec_s3;

		hour_s5 <= hour_s4;
		min_s5  <= min_s4;
		sec_s5  <= sec_s4;
		hour_s6 <= hour_s5;
		min_s6  <= min_s5;
		sec_s6  <= sec_s5;
		hour_s7 <= hour_s6;
		min_s7  <= min_s6;
		sec_s7  <= sec_s6;
		hour_s8 <= hour_s7;
		min_s8  <= min_s7;
		sec_s8  <= sec_s7;
		hour_s9 <= hour_s8;
		min_s9  <= min_s8;
		sec_s9  <= sec_s8;
	end

	// calendar date from the day count
	usutc_civil_date u_civil_date (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s3),
		.day_count (day_s3),
		.out_valid (date_valid),
		.date      (date)
	);

	assign done         = date_valid;
	assign year         = date.year;
	assign month        = date.month;
	assign day_of_month = date.day;
	assign hour         = hour_s9;
	assign minute       = min_s9;
	assign second       = sec_s9;

	`ASSERT_IMPLY(a_done_latency, done, $past(start, usutc_pkg::LATENCY), "done without a request")
	`ASSERT_IMPLY(a_time_range, done,
		second < 6'd60 && minute < 6'd60 && hour < 5'd24, "time of day out of range")
	`ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")

endmodule

`default_nettype wire

// ===== bench/tb_unix_seconds_to_utc_civil_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_unix_seconds_to_utc_civil_unit
// self-checking bench for the unix seconds to utc civil converter: requests
// go in through start/busy, every done strobe is compared field by field
// against an in-bench days-to-civil predictor, in request order
// ----------------------------------------------------------------------------

module tb_unix_seconds_to_utc_civil_unit;

	// run limits
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned SECS_PER_DAY = 86400;
	localparam int unsigned LAST_FULL_DAY = 49709;

	// one predicted civil stamp
	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} utc_stamp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [31:0] epoch_seconds = '0;
	logic        busy;
	logic        done;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	// stamps still owed by the converter, oldest first
	utc_stamp_t  pending_stamps[$];
	int unsigned mismatch_count = 0;
	int unsigned request_count = 0;
	int unsigned stamp_count = 0;
	int unsigned cycle_count = 0;

	unix_seconds_to_utc_civil_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.epoch_seconds(epoch_seconds),
		.done         (done),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

	// 20 ns clock
	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor: seconds to civil stamp, days counted from 0000-03-01
	// ------------------------------------------------------------------------
	function automatic utc_stamp_t civil_of_seconds(input logic [31:0] secs);
		logic [31:0] total_min, total_hr, day_idx, shifted;
		logic [31:0] era, day_of_era, year_of_era, day_of_year;
		logic [31:0] march_month, mday, civil_month, civil_year;
		utc_stamp_t  stamp;
		total_min = secs / 32'd60;
		total_hr  = total_min / 32'd60;
		day_idx   = total_hr / 32'd24;
		// the input is unsigned, so the era never goes negative
		shifted     = day_idx + 32'd719468;
		era         = shifted / 32'd146097;
		day_of_era  = shifted - era * 32'd146097;
		// leap corrections for 4, 100 and 400 year cycles
		year_of_era = (day_of_era - day_of_era / 32'd1460 + day_of_era / 32'd36524
			- day_of_era / 32'd146096) / 32'd365;
		day_of_year = day_of_era - (32'd365 * year_of_era + year_of_era / 32'd4
			- year_of_era / 32'd100);
		// march-based month index, 0 is march
		march_month = (32'd5 * day_of_year + 32'd2) / 32'd153;
		mday        = day_of_year - (32'd153 * march_month + 32'd2) / 32'd5 + 32'd1;
		civil_month = (march_month < 32'd10) ? march_month + 32'd3 : march_month - 32'd9;
		// january and february belong to the next calendar year
		civil_year  = year_of_era + era * 32'd400 + ((civil_month <= 32'd2) ? 32'd1 : 32'd0);
		stamp.year         = civil_year[11:0];
		stamp.month        = civil_month[3:0];
		stamp.day_of_month = mday[4:0];
		stamp.hour         = 5'(total_hr % 32'd24);
		stamp.minute       = 6'(total_min % 32'd60);
		stamp.second       = 6'(secs % 32'd60);
		return stamp;
	endfunction

	// one field compare, reported by name
	task automatic compare_field(input string field, input int unsigned exp_val,
		input int unsigned act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", field, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// ------------------------------------------------------------------------
	// monitor: records accepted requests and checks every done strobe
	// all values read here are the ones from before the edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		utc_stamp_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_stamps.size() == 0) begin
					$error("done strobe with no request outstanding");
					mismatch_count++;
				end else begin
					want = pending_stamps.pop_front();
					stamp_count++;
					compare_field("year", want.year, year);
					compare_field("month", want.month, month);
					compare_field("day_of_month", want.day_of_month, day_of_month);
					compare_field("hour", want.hour, hour);
					compare_field("minute", want.minute, minute);
					compare_field("second", want.second, second);
				end
			end
			// request taken at this edge; pushed after the check above
			if (start && !busy) begin
				pending_stamps.push_back(civil_of_seconds(epoch_seconds));
				request_count++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d stamps outstanding", cycle_count,
				pending_stamps.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// request side helpers
	// ------------------------------------------------------------------------

	// present one request and hold it until the converter takes it
	// start is left high so a following request can go out back to back
	task automatic send_request(input logic [31:0] secs);
		start         <= 1'b1;
		epoch_seconds <= secs;
		do @(posedge clk); while (busy);
	endtask

	// drop start for a number of cycles
	task automatic idle_cycles(input int unsigned n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// gap length: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// hold off new requests until every stamp is back
	task automatic wait_for_drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending_stamps.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// corners of the range, rollover of each field, leap handling
	task automatic test_directed_corners();
		logic [31:0] corners[$];
		corners = '{
			32'd0,            // epoch itself
			32'hFFFF_FFFF,    // top of the range, 2106-02-07 06:28:15
			32'd59, 32'd60,   // second rollover
			32'd3599, 32'd3600,     // minute rollover
			32'd86399, 32'd86400,   // day rollover
			32'd31535999, 32'd31536000,   // end of 1970
			32'd68169600,     // 1972-02-29, first leap day
			32'd946684799,    // last second of 1999
			32'd951782400,    // 2000-02-29, leap by the 400 year rule
			32'd951868800,    // 2000-03-01
			32'd4107542399,   // 2100-02-28 23:59:59
			32'd4107542400,   // 2100-03-01, no leap day in 2100
			32'd2147483647, 32'd2147483648,   // signed 32-bit rollover
			32'h5555_5555, 32'hAAAA_AAAA,
			32'hFFFF_FFFE, 32'h8000_0001
		};
		foreach (corners[i]) begin
			send_request(corners[i]);
			idle_cycles(pick_gap());
		end
		wait_for_drain();
	endtask

	// uniform random seconds over the full range
	task automatic test_uniform_random(input int unsigned n);
		repeat (n) begin
			send_request($urandom());
			idle_cycles(pick_gap());
		end
	endtask

	// random days, seconds placed near midnight, the hour and minute edges
	task automatic test_midnight_edges(input int unsigned n);
		logic [31:0] day_idx, offset;
		repeat (n) begin
			day_idx = $urandom_range(0, LAST_FULL_DAY);
			case ($urandom_range(0, 4))
				0: offset = $urandom_range(0, 2);
				1: offset = SECS_PER_DAY - 1 - $urandom_range(0, 2);
				2: offset = $urandom_range(0, 23) * 3600 + $urandom_range(0, 1);
				3: offset = $urandom_range(0, 1439) * 60 + 59;
				default: offset = $urandom_range(0, SECS_PER_DAY - 1);
			endcase
			send_request(day_idx * SECS_PER_DAY + offset);
			idle_cycles(pick_gap());
		end
	endtask

	// full rate stream, one request every cycle
	task automatic test_back_to_back(input int unsigned n);
		repeat (n) send_request($urandom());
		idle_cycles(1);
	endtask

	// ------------------------------------------------------------------------
	// sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_corners();
		test_uniform_random(600);
		// pause the sender until the pipeline is empty
		wait_for_drain();
		test_midnight_edges(500);
		test_back_to_back(300);
		test_uniform_random(100);

		wait_for_drain();
		repeat (usutc_pkg::LATENCY + 5) @(posedge clk);
		if (pending_stamps.size() != 0) begin
			$error("%0d stamps never arrived", pending_stamps.size());
			mismatch_count++;
		end

		$display("%0d requests sent, %0d stamps checked: corners, uniform range,",
			request_count, stamp_count);
		$display("midnight and hour edges, full-rate stream, gaps and drain pauses");
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
